[hdl/smas_pkg.sv]
// ----------------------------------------------------------------------------
// smas_pkg: shared types and codes for the multiword add/subtract block
// Field widths, action, sign and status codes, and the queue item format
// passed from the front end to the execution back end.
// ----------------------------------------------------------------------------
package smas_pkg;

    localparam int LIMB_W   = 32;
    localparam int INDEX_W  = 5;
    localparam int LEN_W    = 6;
    localparam int ACTION_W = 3;
    localparam int SIGN_W   = 2;
    localparam int STATUS_W = 2;

    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_LOAD_FIRST  = 3'd0;
    localparam action_t ACT_LOAD_SECOND = 3'd1;
    localparam action_t ACT_ADD         = 3'd2;
    localparam action_t ACT_SUB         = 3'd3;
    localparam action_t ACT_ADD_WORD    = 3'd4;
    localparam action_t ACT_SUB_WORD    = 3'd5;

    typedef logic signed [SIGN_W-1:0] sign_t;

    localparam sign_t SIGN_ZERO = 2'sb00;
    localparam sign_t SIGN_POS  = 2'sb01;
    localparam sign_t SIGN_NEG  = 2'sb11;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_OVERFLOW  = 2'd1;
    localparam status_t STAT_UNDERFLOW = 2'd2;

    typedef enum logic [2:0] {
        KIND_LOAD_FIRST,
        KIND_LOAD_SECOND,
        KIND_ADD,
        KIND_SUB,
        KIND_ADD_WORD,
        KIND_SUB_WORD
    } kind_t;

    // Classified item: sign normalized, length saturated to the limb capacity
    typedef struct packed {
        kind_t                   kind;
        sign_t                   sign;
        logic [LEN_W-1:0]        length;
        logic [INDEX_W-1:0]      index;
        logic [LIMB_W-1:0]       value;
    } item_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

endpackage

[hdl/smas_ram.sv]
// ----------------------------------------------------------------------------
// smas_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module smas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/smas_front.sv]
// ----------------------------------------------------------------------------
// smas_front: input classification
// Decode the action, normalize the sign, saturate the length and push the
// item into the queue; drop unused action codes.
// ----------------------------------------------------------------------------
module smas_front #(
    parameter int LIMBS = 32
) (
    input  logic                             in_valid,
    output logic                             in_stall,
    input  smas_pkg::action_t                action,
    input  logic [smas_pkg::SIGN_W-1:0]      operand_sign,
    input  logic [smas_pkg::LEN_W-1:0]       operand_length,
    input  logic [smas_pkg::INDEX_W-1:0]     limb_index,
    input  logic [smas_pkg::LIMB_W-1:0]      limb_value,
    input  logic                             q_full,
    output logic                             push,
    output smas_pkg::item_t                  push_item
);

    logic            known;
    smas_pkg::kind_t kind;

    always_comb
    begin
        known = 1'b1;
        kind  = smas_pkg::KIND_LOAD_FIRST;
        case (action)
            smas_pkg::ACT_LOAD_FIRST:  kind = smas_pkg::KIND_LOAD_FIRST;
            smas_pkg::ACT_LOAD_SECOND: kind = smas_pkg::KIND_LOAD_SECOND;
            smas_pkg::ACT_ADD:         kind = smas_pkg::KIND_ADD;
            smas_pkg::ACT_SUB:         kind = smas_pkg::KIND_SUB;
            smas_pkg::ACT_ADD_WORD:    kind = smas_pkg::KIND_ADD_WORD;
            smas_pkg::ACT_SUB_WORD:    kind = smas_pkg::KIND_SUB_WORD;
            default:                   known = 1'b0;
        endcase
    end

    always_comb
    begin
        push_item.kind = kind;
        // both negative patterns map to -1
        case (operand_sign)
            smas_pkg::SIGN_ZERO: push_item.sign = smas_pkg::SIGN_ZERO;
            smas_pkg::SIGN_POS:  push_item.sign = smas_pkg::SIGN_POS;
            default:             push_item.sign = smas_pkg::SIGN_NEG;
        endcase
        if (32'(operand_length) > LIMBS)
        begin
            push_item.length = smas_pkg::LEN_W'(LIMBS);
        end
        else
        begin
            push_item.length = operand_length;
        end
        push_item.index = limb_index;
        push_item.value = limb_value;
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full && known;

endmodule

[hdl/smas_queue.sv]
// ----------------------------------------------------------------------------
// smas_queue: short item queue between front end and back end
// Register FIFO; full and valid come straight from the fill count.
// ----------------------------------------------------------------------------
module smas_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  smas_pkg::item_t push_item,
    output logic            q_full,
    input  logic            pop,
    output logic            q_valid,
    output smas_pkg::item_t q_item
);

    smas_pkg::item_t                      entry_reg [smas_pkg::QUEUE_DEPTH];
    logic [smas_pkg::QUEUE_AW-1:0]        wr_ptr_reg;
    logic [smas_pkg::QUEUE_AW-1:0]        rd_ptr_reg;
    logic [smas_pkg::QUEUE_CW-1:0]        count_reg;
    logic [smas_pkg::QUEUE_CW-1:0]        count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + smas_pkg::QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - smas_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + smas_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + smas_pkg::QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign q_full  = (count_reg == smas_pkg::QUEUE_CW'(smas_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

endmodule

[hdl/smas_back.sv]
// ----------------------------------------------------------------------------
// smas_back: execution back end
// Hold operand state, walk the limb memories to compare and add/subtract,
// buffer and normalize the result, then stream it out one limb per item.
// ----------------------------------------------------------------------------
module smas_back #(
    parameter int LIMBS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  smas_pkg::item_t                   q_item,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [smas_pkg::LIMB_W-1:0]       result_limb,
    output logic [smas_pkg::INDEX_W-1:0]      result_index,
    output smas_pkg::sign_t                   result_sign,
    output logic [smas_pkg::LEN_W-1:0]        result_length,
    output smas_pkg::status_t                 status,
    output logic                              last
);

    localparam int IW = (LIMBS > 1) ? $clog2(LIMBS) : 1;
    localparam int LW = $clog2(LIMBS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_CALC,
        ST_DONE,
        ST_PRIME,
        ST_EMIT,
        ST_ONE
    } state_t;

    function automatic smas_pkg::sign_t sign_neg(smas_pkg::sign_t s);
        case (s)
            smas_pkg::SIGN_POS: return smas_pkg::SIGN_NEG;
            smas_pkg::SIGN_NEG: return smas_pkg::SIGN_POS;
            default:            return smas_pkg::SIGN_ZERO;
        endcase
    endfunction

    state_t                  state_reg,  state_next;
    smas_pkg::sign_t         fsign_reg,  fsign_next;
    smas_pkg::sign_t         ssign_reg,  ssign_next;
    logic [LW-1:0]           flen_reg,   flen_next;
    logic [LW-1:0]           slen_reg,   slen_next;
    smas_pkg::kind_t         kind_reg,   kind_next;
    logic [31:0]             word_reg,   word_next;
    logic                    swap_reg,   swap_next;
    logic                    sub_reg,    sub_next;
    smas_pkg::sign_t         rsign_reg,  rsign_next;
    logic [LW-1:0]           n_reg,      n_next;
    logic [IW-1:0]           walk_reg,   walk_next;
    logic [LW-1:0]           left_reg,   left_next;
    logic                    pend_reg,   pend_next;
    logic [IW-1:0]           didx_reg,   didx_next;
    logic                    carry_reg,  carry_next;
    logic [LW-1:0]           nz_reg,     nz_next;
    logic [LW-1:0]           rlen_reg,   rlen_next;
    logic [IW-1:0]           ptr_reg,    ptr_next;
    smas_pkg::status_t       status_reg, status_next;

    logic [31:0]             a_q;
    logic [31:0]             b_q;
    logic [31:0]             res_q;
    logic                    a_we;
    logic                    b_we;
    logic                    res_we;
    logic [IW-1:0]           res_waddr;
    logic [31:0]             res_wdata;
    logic [IW-1:0]           res_raddr;
    logic [IW-1:0]           ld_waddr;

    logic [31:0]             a_lv;
    logic [31:0]             b_lv;
    logic [31:0]             x_op;
    logic [31:0]             y_op;
    logic [32:0]             r33;
    logic                    word_op;
    logic                    mag_add;
    logic                    ld_ok;
    logic [LW-1:0]           n_pair;
    logic [LW-1:0]           n_word;
    logic [LW-1:0]           ld_len;
    logic                    accept;
    logic                    emit_last;

    smas_ram #(.WIDTH(32), .DEPTH(LIMBS)) u_first_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (ld_waddr),
        .wdata (q_item.value),
        .raddr (walk_reg),
        .rdata (a_q)
    );

    smas_ram #(.WIDTH(32), .DEPTH(LIMBS)) u_second_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (ld_waddr),
        .wdata (q_item.value),
        .raddr (walk_reg),
        .rdata (b_q)
    );

    smas_ram #(.WIDTH(32), .DEPTH(LIMBS)) u_result_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_q)
    );

    // limb datapath: limbs at or above an operand's length read as zero
    always_comb
    begin
        a_lv    = (LW'(didx_reg) < flen_reg) ? a_q : 32'd0;
        b_lv    = (LW'(didx_reg) < slen_reg) ? b_q : 32'd0;
        word_op = (kind_reg == smas_pkg::KIND_ADD_WORD) ||
                  (kind_reg == smas_pkg::KIND_SUB_WORD);
        x_op    = swap_reg ? b_lv : a_lv;
        if (word_op)
        begin
            y_op = (didx_reg == '0) ? word_reg : 32'd0;
        end
        else
        begin
            y_op = swap_reg ? a_lv : b_lv;
        end
        if (sub_reg)
        begin
            r33 = {1'b0, x_op} - {1'b0, y_op} - {32'd0, carry_reg};
        end
        else
        begin
            r33 = {1'b0, x_op} + {1'b0, y_op} + {32'd0, carry_reg};
        end
    end

    always_comb
    begin
        ld_ok     = (32'(q_item.index) < LIMBS);
        ld_waddr  = IW'(q_item.index);
        ld_len    = LW'(q_item.length);
        n_pair    = (flen_reg > slen_reg) ? flen_reg : slen_reg;
        n_word    = (flen_reg > LW'(1)) ? flen_reg : LW'(1);
        mag_add   = ((fsign_reg == ssign_reg) == (q_item.kind == smas_pkg::KIND_ADD));
        accept    = out_valid && !out_stall;
        emit_last = ((LW'(ptr_reg) + LW'(1)) == rlen_reg);
        res_raddr = (state_reg == ST_EMIT && !out_stall) ? (ptr_reg + IW'(1)) : ptr_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        fsign_next  = fsign_reg;
        ssign_next  = ssign_reg;
        flen_next   = flen_reg;
        slen_next   = slen_reg;
        kind_next   = kind_reg;
        word_next   = word_reg;
        swap_next   = swap_reg;
        sub_next    = sub_reg;
        rsign_next  = rsign_reg;
        n_next      = n_reg;
        walk_next   = walk_reg;
        left_next   = left_reg;
        pend_next   = 1'b0;
        didx_next   = didx_reg;
        carry_next  = carry_reg;
        nz_next     = nz_reg;
        rlen_next   = rlen_reg;
        ptr_next    = ptr_reg;
        status_next = status_reg;
        pop         = 1'b0;
        a_we        = 1'b0;
        b_we        = 1'b0;
        res_we      = 1'b0;
        res_waddr   = didx_reg;
        res_wdata   = r33[31:0];

        // issue one limb read per cycle during the walks
        if ((state_reg == ST_CMP || state_reg == ST_CALC) && left_reg != '0)
        begin
            walk_next = (state_reg == ST_CMP) ? (walk_reg - IW'(1)) : (walk_reg + IW'(1));
            left_next = left_reg - LW'(1);
            pend_next = 1'b1;
            didx_next = walk_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop         = 1'b1;
                    kind_next   = q_item.kind;
                    word_next   = q_item.value;
                    status_next = smas_pkg::STAT_OK;
                    walk_next   = '0;
                    pend_next   = 1'b0;
                    carry_next  = 1'b0;
                    nz_next     = '0;
                    swap_next   = 1'b0;
                    case (q_item.kind)
                        smas_pkg::KIND_LOAD_FIRST:
                        begin
                            a_we       = ld_ok;
                            fsign_next = q_item.sign;
                            flen_next  = ld_len;
                        end
                        smas_pkg::KIND_LOAD_SECOND:
                        begin
                            b_we       = ld_ok;
                            ssign_next = q_item.sign;
                            slen_next  = ld_len;
                        end
                        smas_pkg::KIND_ADD, smas_pkg::KIND_SUB:
                        begin
                            n_next = n_pair;
                            if (mag_add)
                            begin
                                sub_next = 1'b0;
                                if (q_item.kind == smas_pkg::KIND_ADD ||
                                    fsign_reg != smas_pkg::SIGN_ZERO)
                                begin
                                    rsign_next = fsign_reg;
                                end
                                else
                                begin
                                    rsign_next = sign_neg(ssign_reg);
                                end
                                left_next  = n_pair;
                                state_next = (n_pair == '0) ? ST_DONE : ST_CALC;
                            end
                            else if (n_pair == '0)
                            begin
                                // equal (empty) magnitudes cancel
                                rsign_next = smas_pkg::SIGN_ZERO;
                                rlen_next  = '0;
                                state_next = ST_ONE;
                            end
                            else
                            begin
                                walk_next  = IW'(n_pair - LW'(1));
                                left_next  = n_pair;
                                state_next = ST_CMP;
                            end
                        end
                        smas_pkg::KIND_ADD_WORD:
                        begin
                            sub_next   = 1'b0;
                            rsign_next = fsign_reg;
                            n_next     = n_word;
                            left_next  = n_word;
                            state_next = ST_CALC;
                        end
                        smas_pkg::KIND_SUB_WORD:
                        begin
                            sub_next   = 1'b1;
                            rsign_next = fsign_reg;
                            n_next     = flen_reg;
                            left_next  = flen_reg;
                            if (flen_reg == '0)
                            begin
                                // nothing to borrow from: any nonzero word underflows
                                carry_next = (q_item.value != 32'd0);
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_CALC;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CMP:
            begin
                if (pend_reg)
                begin
                    if (a_lv != b_lv)
                    begin
                        sub_next = 1'b1;
                        if (a_lv > b_lv)
                        begin
                            swap_next  = 1'b0;
                            rsign_next = fsign_reg;
                        end
                        else
                        begin
                            swap_next  = 1'b1;
                            rsign_next = (kind_reg == smas_pkg::KIND_ADD) ?
                                         ssign_reg : sign_neg(ssign_reg);
                        end
                        walk_next  = '0;
                        left_next  = n_reg;
                        pend_next  = 1'b0;
                        carry_next = 1'b0;
                        nz_next    = '0;
                        state_next = ST_CALC;
                    end
                    else if (left_reg == '0)
                    begin
                        rsign_next = smas_pkg::SIGN_ZERO;
                        rlen_next  = '0;
                        state_next = ST_ONE;
                    end
                end
            end

            ST_CALC:
            begin
                if (pend_reg)
                begin
                    res_we     = 1'b1;
                    carry_next = r33[32];
                    if (r33[31:0] != 32'd0)
                    begin
                        nz_next = LW'(didx_reg) + LW'(1);
                    end
                    if (left_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                ptr_next = '0;
                if (carry_reg)
                begin
                    if (sub_reg)
                    begin
                        status_next = smas_pkg::STAT_UNDERFLOW;
                        rsign_next  = smas_pkg::SIGN_ZERO;
                        rlen_next   = '0;
                        state_next  = ST_ONE;
                    end
                    else if (n_reg == LW'(LIMBS))
                    begin
                        status_next = smas_pkg::STAT_OVERFLOW;
                        rsign_next  = smas_pkg::SIGN_ZERO;
                        rlen_next   = '0;
                        state_next  = ST_ONE;
                    end
                    else
                    begin
                        // carry out becomes a new top limb
                        res_we     = 1'b1;
                        res_waddr  = IW'(n_reg);
                        res_wdata  = 32'd1;
                        rlen_next  = n_reg + LW'(1);
                        state_next = ST_PRIME;
                    end
                end
                else
                begin
                    rlen_next = nz_reg;
                    if (nz_reg == '0)
                    begin
                        if (!word_op)
                        begin
                            rsign_next = smas_pkg::SIGN_ZERO;
                        end
                        state_next = ST_ONE;
                    end
                    else
                    begin
                        state_next = ST_PRIME;
                    end
                end
            end

            ST_PRIME:
            begin
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (accept)
                begin
                    ptr_next = ptr_reg + IW'(1);
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_ONE:
            begin
                if (accept)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fsign_reg  <= smas_pkg::SIGN_ZERO;
            ssign_reg  <= smas_pkg::SIGN_ZERO;
            flen_reg   <= '0;
            slen_reg   <= '0;
            kind_reg   <= smas_pkg::KIND_LOAD_FIRST;
            word_reg   <= '0;
            swap_reg   <= 1'b0;
            sub_reg    <= 1'b0;
            rsign_reg  <= smas_pkg::SIGN_ZERO;
            n_reg      <= '0;
            walk_reg   <= '0;
            left_reg   <= '0;
            pend_reg   <= 1'b0;
            didx_reg   <= '0;
            carry_reg  <= 1'b0;
            nz_reg     <= '0;
            rlen_reg   <= '0;
            ptr_reg    <= '0;
            status_reg <= smas_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            fsign_reg  <= fsign_next;
            ssign_reg  <= ssign_next;
            flen_reg   <= flen_next;
            slen_reg   <= slen_next;
            kind_reg   <= kind_next;
            word_reg   <= word_next;
            swap_reg   <= swap_next;
            sub_reg    <= sub_next;
            rsign_reg  <= rsign_next;
            n_reg      <= n_next;
            walk_reg   <= walk_next;
            left_reg   <= left_next;
            pend_reg   <= pend_next;
            didx_reg   <= didx_next;
            carry_reg  <= carry_next;
            nz_reg     <= nz_next;
            rlen_reg   <= rlen_next;
            ptr_reg    <= ptr_next;
            status_reg <= status_next;
        end
    end

    assign out_valid     = (state_reg == ST_EMIT) || (state_reg == ST_ONE);
    assign result_limb   = (state_reg == ST_ONE) ? 32'd0 : res_q;
    assign result_index  = (state_reg == ST_ONE) ? '0 : smas_pkg::INDEX_W'(ptr_reg);
    assign result_sign   = rsign_reg;
    assign result_length = smas_pkg::LEN_W'(rlen_reg);
    assign status        = status_reg;
    assign last          = (state_reg == ST_ONE) || emit_last;

endmodule

[hdl/signed_multiword_add_sub.sv]
// ----------------------------------------------------------------------------
// signed_multiword_add_sub: sign-magnitude multiword add and subtract
// Loads two operands limb by limb, then adds or subtracts them (or a single
// word) and streams the normalized magnitude out, low limb first.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ------------------------------------------------
//  in       in_valid / in_stall  action, operand_sign, operand_length,
//                                limb_index, limb_value
//  out      out_valid/out_stall  result_limb, result_index, result_sign,
//                                result_length, status, last
//
//  Order: the back end writes a load's limb as it pops the item. An operation
//  over n limbs (n = longer operand length) leaves the queue, runs a compare
//  walk when needed (add of unlike signs, subtract of like signs), then the
//  add/subtract walk, settles the length and primes the result read, then
//  streams out the result items, low limb first. The walks are set
//  by the single read port of each limb memory, one limb per cycle.
//  Reset clears signs, lengths and control; limb memories hold no reset value
//  and need no clearing pass. A full two-entry queue raises in_stall; a
//  stalled output holds its item and the walk behind it waits.
//
module signed_multiword_add_sub #(
    parameter int LIMBS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input item channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  smas_pkg::action_t                 action,
    input  logic [smas_pkg::SIGN_W-1:0]       operand_sign,
    input  logic [smas_pkg::LEN_W-1:0]        operand_length,
    input  logic [smas_pkg::INDEX_W-1:0]      limb_index,
    input  logic [smas_pkg::LIMB_W-1:0]       limb_value,
    // result item channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [smas_pkg::LIMB_W-1:0]       result_limb,
    output logic [smas_pkg::INDEX_W-1:0]      result_index,
    output smas_pkg::sign_t                   result_sign,
    output logic [smas_pkg::LEN_W-1:0]        result_length,
    output smas_pkg::status_t                 status,
    output logic                              last
);

    logic            push;
    smas_pkg::item_t push_item;
    logic            q_full;
    logic            q_valid;
    logic            pop;
    smas_pkg::item_t q_item;

    // Front end: classify each item, drop unused actions, push into the queue
    smas_front #(.LIMBS(LIMBS)) u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .operand_sign   (operand_sign),
        .operand_length (operand_length),
        .limb_index     (limb_index),
        .limb_value     (limb_value),
        .q_full         (q_full),
        .push           (push),
        .push_item      (push_item)
    );

    // Queue: decouple input acceptance from the limb walks
    smas_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Back end: execute loads and operations in order, stream results
    smas_back #(.LIMBS(LIMBS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_limb   (result_limb),
        .result_index  (result_index),
        .result_sign   (result_sign),
        .result_length (result_length),
        .status        (status),
        .last          (last)
    );

endmodule

[hdl/smas_checker.sv]
// ----------------------------------------------------------------------------
// smas_checker: port-level checks for the multiword add/subtract block
// Watches the result channel for stream ordering and error item format.
// ----------------------------------------------------------------------------
module smas_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [smas_pkg::LIMB_W-1:0]       result_limb,
    input  logic [smas_pkg::INDEX_W-1:0]      result_index,
    input  smas_pkg::sign_t                   result_sign,
    input  logic [smas_pkg::LEN_W-1:0]        result_length,
    input  smas_pkg::status_t                 status,
    input  logic                              last
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_limb) &&
            $stable(result_index) && $stable(last) && $stable(result_length))
        else $error("stalled result item changed");

    // the marked item of a nonempty result is its top limb
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && result_length != '0 |->
            {1'b0, result_index} == result_length - smas_pkg::LEN_W'(1))
        else $error("last mark not on top limb");

    // an error is reported as one empty item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != smas_pkg::STAT_OK |->
            last && result_length == '0 && result_limb == '0 &&
            result_sign == smas_pkg::SIGN_ZERO)
        else $error("error item malformed");

    // an empty result is a single zero item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_length == '0 |->
            last && result_limb == '0 && result_index == '0)
        else $error("empty result item malformed");

    // limbs of one result follow in order
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last ##1 out_valid |->
            result_index == $past(result_index) + smas_pkg::INDEX_W'(1))
        else $error("result limb out of order");

endmodule

bind signed_multiword_add_sub smas_checker u_smas_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_limb    (result_limb),
    .result_index   (result_index),
    .result_sign    (result_sign),
    .result_length  (result_length),
    .status         (status),
    .last           (last)
);

[tb/smas_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smas_result_checker: predicts and checks multiword add/subtract results
// Watches both channels of the block, keeps its own copy of the two operands,
// works out the result items of every accepted input item and compares each
// accepted result item with the oldest one still pending.
// ----------------------------------------------------------------------------
module smas_result_checker #(
    parameter int LIMBS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  smas_pkg::action_t                 action,
    input  logic [smas_pkg::SIGN_W-1:0]       operand_sign,
    input  logic [smas_pkg::LEN_W-1:0]        operand_length,
    input  logic [smas_pkg::INDEX_W-1:0]      limb_index,
    input  logic [smas_pkg::LIMB_W-1:0]       limb_value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [smas_pkg::LIMB_W-1:0]       result_limb,
    input  logic [smas_pkg::INDEX_W-1:0]      result_index,
    input  smas_pkg::sign_t                   result_sign,
    input  logic [smas_pkg::LEN_W-1:0]        result_length,
    input  smas_pkg::status_t                 status,
    input  logic                              last,
    output int                                failures,
    output int                                outstanding
);
    import smas_pkg::*;

    localparam int MAG_W      = LIMBS * LIMB_W;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic [LIMB_W-1:0]  limb;
        logic [INDEX_W-1:0] index;
        sign_t              sign;
        logic [LEN_W-1:0]   length;
        status_t            status;
        logic               last;
    } limb_result_t;

    limb_result_t      pending_limbs [$];
    logic [LIMB_W-1:0] first_limbs  [LIMBS];
    logic [LIMB_W-1:0] second_limbs [LIMBS];
    int                first_sign;
    int                second_sign;
    int                first_len;
    int                second_len;

    initial
    begin
        failures    = 0;
        outstanding = 0;
        first_sign  = 0;
        second_sign = 0;
        first_len   = 0;
        second_len  = 0;
        for (int i = 0; i < LIMBS; i++)
        begin
            first_limbs[i]  = '0;
            second_limbs[i] = '0;
        end
    end

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        failures++;
        $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    function automatic sign_t sign_code(int s);
        if (s > 0)
            return SIGN_POS;
        if (s < 0)
            return SIGN_NEG;
        return SIGN_ZERO;
    endfunction

    // both remaining patterns read as negative
    function automatic int sign_value(logic [SIGN_W-1:0] bits);
        if (bits == SIGN_ZERO)
            return 0;
        if (bits == SIGN_POS)
            return 1;
        return -1;
    endfunction

    // limbs at or above the length count as zero
    function automatic mag_t magnitude(bit second);
        mag_t m;
        int   n;
        m = '0;
        n = second ? second_len : first_len;
        for (int i = 0; i < LIMBS; i++)
            if (i < n)
                m[i*LIMB_W +: LIMB_W] = second ? second_limbs[i] : first_limbs[i];
        return m;
    endfunction

    function automatic int used_limbs(mag_t m);
        int n;
        n = LIMBS;
        while (n > 0 && m[(n-1)*LIMB_W +: LIMB_W] == '0)
            n--;
        return n;
    endfunction

    task automatic queue_result(logic [LIMB_W-1:0] limb, int idx, int sgn, int len,
                                status_t st, logic fin);
        limb_result_t e;
        e.limb   = limb;
        e.index  = idx[INDEX_W-1:0];
        e.sign   = sign_code(sgn);
        e.length = len[LEN_W-1:0];
        e.status = st;
        e.last   = fin;
        pending_limbs.push_back(e);
    endtask

    task automatic queue_magnitude(mag_t m, int sgn);
        int n;
        n = used_limbs(m);
        if (n == 0)
            queue_result('0, 0, sgn, 0, STAT_OK, 1'b1);
        for (int k = 0; k < n; k++)
            queue_result(m[k*LIMB_W +: LIMB_W], k, sgn, n, STAT_OK, k == n - 1);
    endtask

    task automatic compute_results(action_t act, logic [SIGN_W-1:0] sbits,
                                   logic [LEN_W-1:0] len_field, logic [INDEX_W-1:0] idx,
                                   logic [LIMB_W-1:0] val);
        int             len;
        int             rsign;
        mag_t           x;
        mag_t           y;
        mag_t           r;
        logic [MAG_W:0] sum;
        len   = (len_field > LIMBS) ? LIMBS : len_field;
        x     = magnitude(1'b0);
        y     = magnitude(1'b1);
        rsign = 0;
        r     = '0;
        case (act)
            ACT_LOAD_FIRST:
            begin
                if (idx < LIMBS)
                    first_limbs[idx] = val;
                first_sign = sign_value(sbits);
                first_len  = len;
            end
            ACT_LOAD_SECOND:
            begin
                if (idx < LIMBS)
                    second_limbs[idx] = val;
                second_sign = sign_value(sbits);
                second_len  = len;
            end
            ACT_ADD, ACT_SUB:
            begin
                if ((first_sign == second_sign) == (act == ACT_ADD))
                begin
                    if (act == ACT_ADD)
                        rsign = first_sign;
                    else
                        rsign = (first_sign != 0) ? first_sign : -second_sign;
                    sum = {1'b0, x} + {1'b0, y};
                    r   = sum[MAG_W-1:0];
                end
                else if (x > y)
                begin
                    rsign = first_sign;
                    r     = x - y;
                end
                else if (x < y)
                begin
                    rsign = (act == ACT_ADD) ? second_sign : -second_sign;
                    r     = y - x;
                end
                if ((first_sign == second_sign) == (act == ACT_ADD) && sum[MAG_W])
                    queue_result('0, 0, 0, 0, STAT_OVERFLOW, 1'b1);
                else
                begin
                    if (r == '0)
                        rsign = 0;
                    queue_magnitude(r, rsign);
                end
            end
            ACT_ADD_WORD:
            begin
                sum = {1'b0, x} + val;
                if (sum[MAG_W])
                    queue_result('0, 0, 0, 0, STAT_OVERFLOW, 1'b1);
                else
                    queue_magnitude(sum[MAG_W-1:0], first_sign);
            end
            ACT_SUB_WORD:
            begin
                if (val > x)
                    queue_result('0, 0, 0, 0, STAT_UNDERFLOW, 1'b1);
                else
                    queue_magnitude(x - val, first_sign);
            end
            default:
                ;
        endcase
    endtask

    task automatic check_result();
        limb_result_t e;
        if (pending_limbs.size() == 0)
            flag_mismatch("result item with none pending", '0, result_limb);
        else
        begin
            e = pending_limbs.pop_front();
            if (result_limb !== e.limb)
                flag_mismatch("result_limb", e.limb, result_limb);
            if (result_index !== e.index)
                flag_mismatch("result_index", 32'(e.index), 32'(result_index));
            if (result_sign !== e.sign)
                flag_mismatch("result_sign", 32'(e.sign), 32'(result_sign));
            if (result_length !== e.length)
                flag_mismatch("result_length", 32'(e.length), 32'(result_length));
            if (status !== e.status)
                flag_mismatch("status", 32'(e.status), 32'(status));
            if (last !== e.last)
                flag_mismatch("last", 32'(e.last), 32'(last));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                compute_results(action, operand_sign, operand_length, limb_index,
                                limb_value);
        end
        outstanding <= pending_limbs.size();
    end

endmodule

[tb/tb_signed_multiword_add_sub.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_multiword_add_sub: stimulus and verdict for the multiword adder
// Drives directed and random load/operate sequences with random gaps and
// output stalls; the result checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_signed_multiword_add_sub;
    import smas_pkg::*;

    localparam int LIMBS       = 32;
    localparam int ITEM_TARGET = 470;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 200;

    // unused action codes, ignored by the block
    localparam action_t ACT_SPARE_LO = 3'd6;
    localparam action_t ACT_SPARE_HI = 3'd7;

    // second encoding of a negative sign
    localparam logic [SIGN_W-1:0] SIGN_NEG_ALT = 2'b10;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZERO,
        FILL_TINY,
        FILL_MIXED
    } fill_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    action_t               action         = ACT_LOAD_FIRST;
    logic [SIGN_W-1:0]     operand_sign   = '0;
    logic [LEN_W-1:0]      operand_length = '0;
    logic [INDEX_W-1:0]    limb_index     = '0;
    logic [LIMB_W-1:0]     limb_value     = '0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [LIMB_W-1:0]     result_limb;
    logic [INDEX_W-1:0]    result_index;
    sign_t                 result_sign;
    logic [LEN_W-1:0]      result_length;
    status_t               status;
    logic                  last;

    int                    failures;
    int                    outstanding;

    // idle-pattern control (calm is shared by sender and receiver), cycle count
    logic                  calm           = 1'b0;
    int                    calm_left      = 0;
    int                    stall_left     = 0;
    int                    cycles         = 0;

    // which limbs of each operand have been written so far
    logic [LIMBS-1:0]      first_written  = '0;
    logic [LIMBS-1:0]      second_written = '0;
    logic [LIMB_W-1:0]     first_vals [LIMBS];
    int                    first_n        = 0;
    int                    items_sent     = 0;

    signed_multiword_add_sub #(
        .LIMBS(LIMBS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .operand_sign  (operand_sign),
        .operand_length(operand_length),
        .limb_index    (limb_index),
        .limb_value    (limb_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_limb   (result_limb),
        .result_index  (result_index),
        .result_sign   (result_sign),
        .result_length (result_length),
        .status        (status),
        .last          (last)
    );

    smas_result_checker #(
        .LIMBS(LIMBS)
    ) results_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .operand_sign  (operand_sign),
        .operand_length(operand_length),
        .limb_index    (limb_index),
        .limb_value    (limb_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_limb   (result_limb),
        .result_index  (result_index),
        .result_sign   (result_sign),
        .result_length (result_length),
        .status        (status),
        .last          (last),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall at random, now and then for a long stretch; during calm
    // phases take every result item at once.
    always @(posedge clk)
    begin : rx_pattern
        int r;
        if (calm_left == 0)
        begin
            calm      <= ($urandom_range(3, 0) == 0);
            calm_left = $urandom_range(400, 100);
        end
        else
            calm_left = calm_left - 1;
        r = $urandom_range(99, 0);
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (calm || r < 70)
            out_stall <= 1'b0;
        else if (r < 96)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(2, 0);
        end
        else
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(30, 10);
        end
    end

    // Drop valid for a random gap before the next item; mostly none.
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(99, 0);
        if (calm || r < 70)
            n = 0;
        else if (r < 96)
            n = $urandom_range(3, 1);
        else
            n = $urandom_range(40, 10);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Present one item and hold it until the block takes it. Valid stays
    // high on return so a back-to-back item needs no second assignment.
    task automatic send_item(action_t act, logic [SIGN_W-1:0] sgn, logic [LEN_W-1:0] len,
                             logic [INDEX_W-1:0] idx, logic [LIMB_W-1:0] val);
        sender_gap();
        action         <= act;
        operand_sign   <= sgn;
        operand_length <= len;
        limb_index     <= idx;
        limb_value     <= val;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (act <= ACT_SUB_WORD)
            items_sent++;
    endtask

    // Hold off until every pending result item has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic int written_run(logic [LIMBS-1:0] m);
        int n;
        n = 0;
        while (n < LIMBS && m[n])
            n++;
        return n;
    endfunction

    // Load one limb. Clamp the length so that no later operation reads a
    // limb that was never written; above LIMBS the length saturates and
    // needs every limb.
    task automatic load_limb(bit second, logic [SIGN_W-1:0] sgn, int idx,
                             logic [LIMB_W-1:0] val, int want);
        int run;
        if (second)
            second_written[idx] = 1'b1;
        else
            first_written[idx] = 1'b1;
        run = written_run(second ? second_written : first_written);
        if (((want > LIMBS) ? LIMBS : want) > run)
            want = $urandom_range(run, 0);
        send_item(second ? ACT_LOAD_SECOND : ACT_LOAD_FIRST, sgn, want[LEN_W-1:0],
                  idx[INDEX_W-1:0], val);
    endtask

    function automatic logic [LIMB_W-1:0] pick_limb(fill_t fill);
        case (fill)
            FILL_RANDOM: return $urandom;
            FILL_ONES:   return '1;
            FILL_ZERO:   return '0;
            FILL_TINY:   return $urandom_range(3, 0);
            default:
                case ($urandom_range(3, 0))
                    0:       return $urandom;
                    1:       return '1;
                    2:       return '0;
                    default: return $urandom_range(3, 0);
                endcase
        endcase
    endfunction

    function automatic logic [SIGN_W-1:0] pick_sign();
        int r;
        r = $urandom_range(99, 0);
        if (r < 45)
            return SIGN_POS;
        if (r < 80)
            return SIGN_NEG;
        if (r < 90)
            return SIGN_NEG_ALT;
        return SIGN_ZERO;
    endfunction

    // mostly short operands, now and then a full one
    function automatic int pick_size();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70)
            return $urandom_range(4, 1);
        if (r < 90)
            return $urandom_range(12, 5);
        return LIMBS;
    endfunction

    function automatic action_t pick_op();
        case ($urandom_range(3, 0))
            0:       return ACT_ADD;
            1:       return ACT_SUB;
            2:       return ACT_ADD_WORD;
            default: return ACT_SUB_WORD;
        endcase
    endfunction

    // Load an operand low limb first, length growing with each limb.
    // A mirrored second operand repeats the first one's limbs.
    task automatic load_operand(bit second, int n, fill_t fill, bit mirror);
        logic [SIGN_W-1:0] sgn;
        logic [LIMB_W-1:0] v;
        int                want;
        sgn = pick_sign();
        if (!second)
            first_n = n;
        for (int i = 0; i < n; i++)
        begin
            v = mirror ? first_vals[i] : pick_limb(fill);
            if (!second)
                first_vals[i] = v;
            want = i + 1;
            if (i == n - 1 && n == LIMBS && $urandom_range(3, 0) == 0)
                want = $urandom_range(63, LIMBS);
            else if ($urandom_range(15, 0) == 0)
                want = $urandom_range(i + 1, 0);
            load_limb(second, sgn, i, v, want);
        end
    endtask

    // Operations ignore sign, length and index: randomize them anyway.
    task automatic run_op(action_t act);
        send_item(act, SIGN_W'($urandom), LEN_W'($urandom), INDEX_W'($urandom),
                  pick_limb(fill_t'($urandom_range(4, 0))));
    endtask

    task automatic noise_item();
        action_t a;
        a = action_t'($urandom_range(7, 0));
        if (a == ACT_LOAD_FIRST || a == ACT_LOAD_SECOND)
            load_limb(a == ACT_LOAD_SECOND, SIGN_W'($urandom), $urandom_range(LIMBS - 1, 0),
                      $urandom, $urandom_range(63, 0));
        else
            send_item(a, SIGN_W'($urandom), LEN_W'($urandom), INDEX_W'($urandom), $urandom);
    endtask

    initial
    begin : stimulus
        int    r;
        int    n;
        int    next_pause;
        fill_t fill;

        for (int i = 0; i < LIMBS; i++)
            first_vals[i] = '0;

        // Hold reset, then release it on a clock edge.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Operate on the reset operands: zero results, a word underflow and a word add.
        send_item(ACT_ADD, '1, '1, '1, '1);
        send_item(ACT_SUB_WORD, SIGN_ZERO, '0, '0, '0);
        send_item(ACT_SUB_WORD, SIGN_ZERO, '0, '0, 32'd1);
        send_item(ACT_ADD_WORD, SIGN_ZERO, '0, '0, '1);
        // All-ones limb against one: carry into a new limb both ways.
        load_limb(1'b0, SIGN_POS, 0, '1, 1);
        load_limb(1'b1, SIGN_POS, 0, 32'd1, 1);
        send_item(ACT_ADD, SIGN_ZERO, '0, '0, '0);
        send_item(ACT_SUB, SIGN_ZERO, '0, '0, '0);
        send_item(ACT_ADD_WORD, SIGN_ZERO, '0, '0, 32'd1);
        send_item(ACT_SUB_WORD, SIGN_ZERO, '0, '0, '1);
        // Negative through the alternate pattern; equal magnitudes cancel.
        load_limb(1'b1, SIGN_NEG_ALT, 0, '1, 1);
        send_item(ACT_SUB, SIGN_ZERO, '0, '0, '0);
        send_item(ACT_ADD, SIGN_ZERO, '0, '0, '0);
        // Leading zero limb on a negative operand.
        load_limb(1'b0, SIGN_NEG, 1, '0, 2);
        send_item(ACT_SUB_WORD, SIGN_ZERO, '0, '0, 32'h8000_0000);
        send_item(ACT_ADD, SIGN_ZERO, '0, '0, '0);
        // Unused codes must be dropped.
        send_item(ACT_SPARE_LO, '1, '1, '1, '1);
        send_item(ACT_SPARE_HI, '0, '0, '0, '0);
        // Zero second operand.
        load_limb(1'b1, SIGN_ZERO, 0, '0, 0);
        send_item(ACT_SUB, SIGN_ZERO, '0, '0, '0);
        send_item(ACT_ADD, SIGN_ZERO, '0, '0, '0);
        load_limb(1'b0, SIGN_POS, 0, 32'd5, 1);
        send_item(ACT_SUB_WORD, SIGN_ZERO, '0, '0, 32'd6);
        send_item(ACT_SUB, SIGN_ZERO, '0, '0, '0);
        drain();

        // ---- random part ----
        // Open with full all-ones operands to reach overflow.
        load_operand(1'b0, LIMBS, FILL_ONES, 1'b0);
        load_operand(1'b1, LIMBS, FILL_ONES, 1'b1);
        run_op(ACT_ADD);
        run_op(ACT_ADD_WORD);
        run_op(ACT_SUB);
        run_op(ACT_SUB_WORD);

        next_pause = items_sent + $urandom_range(150, 60);
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(99, 0);
            if (r < 75)
            begin
                // well-formed: load operands, then a few operations on them
                if ($urandom_range(4, 0) != 0)
                begin
                    n    = pick_size();
                    fill = (n == LIMBS && $urandom_range(9, 0) < 6) ? FILL_ONES
                                                                  : fill_t'($urandom_range(4, 0));
                    load_operand(1'b0, n, fill, 1'b0);
                end
                if ($urandom_range(99, 0) < 30)
                    load_operand(1'b1, first_n, FILL_MIXED, 1'b1);
                else
                begin
                    n = pick_size();
                    load_operand(1'b1, n, fill_t'($urandom_range(4, 0)), 1'b0);
                end
                repeat ($urandom_range(4, 1))
                    run_op(pick_op());
            end
            else if (r < 90)
                noise_item();
            else
            begin
                // broken: scattered limbs, then operate at once
                repeat ($urandom_range(3, 1))
                    load_limb(1'($urandom_range(1, 0)), pick_sign(),
                              $urandom_range(LIMBS - 1, 0), $urandom, $urandom_range(63, 0));
                run_op(pick_op());
            end
            // Pause the sender now and then until everything is back.
            if (items_sent >= next_pause)
            begin
                drain();
                next_pause = items_sent + $urandom_range(150, 60);
            end
        end

        // Wait for the last results, then let any stray item show up.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/smas_pkg.sv
hdl/smas_ram.sv
hdl/smas_front.sv
hdl/smas_queue.sv
hdl/smas_back.sv
hdl/signed_multiword_add_sub.sv
hdl/smas_checker.sv
tb/smas_result_checker.sv
tb/tb_signed_multiword_add_sub.sv
